[design/csta_pkg.sv]
// Package for the C-SCAN track request arbiter.
// Holds the field widths, default sizes, command and status codes, FSM states and pick type.
// No dependencies.
`timescale 1ns / 1ps

package csta_pkg;

    localparam int TRACK_W          = 7;
    localparam int STATUS_W         = 2;
    localparam int NUM_TRACKS_DEF   = 128;
    localparam int COUNT_BITS_DEF   = 8;

    typedef enum logic
    {
        CMD_REQUEST = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STAT_OK       = 2'd0,
        STAT_IDLE_REL = 2'd1,
        STAT_SAT      = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed
    {
        logic               found;
        logic [TRACK_W-1:0] idx;
    } pick_t;

endpackage

[design/csta_ifs.sv]
// Handshake channels of the C-SCAN track request arbiter: request items in, result items out.
// Depends on csta_pkg for field widths.
`timescale 1ns / 1ps

interface csta_req_if
    import csta_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [TRACK_W-1:0] track;

    modport source (output valid, output cmd, output track, input ready);
    modport sink   (input valid, input cmd, input track, output ready);
endinterface

interface csta_res_if
    import csta_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                granted;
    logic [TRACK_W-1:0]  grant_track;
    logic                disk_busy;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted, output grant_track, output disk_busy,
                    output status, input ready);
    modport sink   (input valid, input granted, input grant_track, input disk_busy,
                    input status, output ready);
endinterface

[design/cscan_track_request_arbiter.sv]
// C-SCAN track request arbiter for one shared disk arm.
//
// Channels: request (sink) carries cmd and track; result (source) carries granted,
// grant_track, disk_busy and status. Both use valid/ready; an item moves when both are high.
// Each request item gives exactly one result item.
// A request to an idle disk is granted at once; to a busy disk it adds one waiter on its
// track, or reports saturation when its count is full. A release grants the next track
// with waiters in C-SCAN order from the head track, or idles the disk when none wait.
// Sequence: one item at a time, stepping through search, count read and update before the
// result goes valid. The count read through the single RAM read port and the registered
// rotating priority encoder set these steps; the next item is taken in the cycle after the
// update, while the result may still wait in its output register.
// Reset: counts read as zero (a per-track nonzero bitmap masks the RAM, no clearing pass),
// disk idle, head track 0; ready is high right after reset in the idle state.
// Stall: when the receiver holds ready low, the result stays in the output register and an
// item that reaches its update step waits there until the register frees.
// Depends on csta_pkg, csta_ifs, csta_ram, csta_finder.
`timescale 1ns / 1ps

module cscan_track_request_arbiter
    import csta_pkg::*;
#(
    parameter int NUM_TRACKS = NUM_TRACKS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    csta_req_if.sink   request,
    csta_res_if.source result
);

    localparam int USED_TRACKS = (NUM_TRACKS < (1 << TRACK_W)) ? NUM_TRACKS : (1 << TRACK_W);
    localparam int IDX_W       = $clog2(USED_TRACKS);

    state_t                 state_reg;
    state_t                 state_next;
    logic                   cmd_reg;
    logic [IDX_W-1:0]       trk_reg;
    logic [IDX_W-1:0]       trk_clamped;
    logic                   busy_reg;
    logic                   busy_next;
    logic [IDX_W-1:0]       head_reg;
    logic [IDX_W-1:0]       head_next;
    logic [USED_TRACKS-1:0] nonzero_reg;
    logic [USED_TRACKS-1:0] nonzero_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   granted_reg;
    logic                   granted_next;
    logic [TRACK_W-1:0]     gtrack_reg;
    logic [TRACK_W-1:0]     gtrack_next;
    logic                   obusy_reg;
    logic                   obusy_next;
    status_t                status_reg;
    status_t                status_next;

    pick_t                  pick;
    logic                   accept;
    logic                   can_out;
    logic                   load;
    logic [IDX_W-1:0]       addr;
    logic [COUNT_BITS-1:0]  rdata;
    logic [COUNT_BITS-1:0]  cnt;
    logic                   ram_we;
    logic                   ram_re;
    logic                   finder_en;
    logic [COUNT_BITS-1:0]  wdata;

    csta_finder #(
        .USED_TRACKS (USED_TRACKS),
        .IDX_W       (IDX_W)
    ) u_finder (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (finder_en),
        .nonzero (nonzero_reg),
        .start   (head_reg),
        .pick    (pick)
    );

    csta_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (USED_TRACKS)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (rdata)
    );

    assign trk_clamped = ({{(32 - TRACK_W){1'b0}}, request.track} >= 32'(NUM_TRACKS))
                       ? IDX_W'(USED_TRACKS - 1) : IDX_W'(request.track);

    assign accept  = request.valid && request.ready;
    assign can_out = !out_valid_reg || result.ready;
    assign load    = (state_reg == ST_UPDATE) && can_out;
    assign addr    = (cmd_reg == CMD_REQUEST) ? trk_reg : pick.idx[IDX_W-1:0];
    assign cnt     = nonzero_reg[addr] ? rdata : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: state_next = ST_READ;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (can_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        request.ready = (state_reg == ST_IDLE);
        finder_en     = (state_reg == ST_SEARCH);
        ram_re        = (state_reg == ST_READ);
    end

    // update step
    always_comb
    begin
        busy_next      = busy_reg;
        head_next      = head_reg;
        nonzero_next   = nonzero_reg;
        ram_we         = 1'b0;
        wdata          = cnt;
        granted_next   = granted_reg;
        gtrack_next    = gtrack_reg;
        obusy_next     = obusy_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            granted_next   = 1'b0;
            gtrack_next    = '0;
            status_next    = STAT_OK;
            if (cmd_reg == CMD_REQUEST)
            begin
                priority if (!busy_reg)
                begin
                    busy_next    = 1'b1;
                    head_next    = trk_reg;
                    granted_next = 1'b1;
                    gtrack_next  = TRACK_W'(trk_reg);
                end
                else if (cnt == {COUNT_BITS{1'b1}})
                begin
                    status_next = STAT_SAT;
                end
                else
                begin
                    ram_we             = 1'b1;
                    wdata              = cnt + 1'b1;
                    nonzero_next[addr] = 1'b1;
                end
            end
            else
            begin
                priority if (!busy_reg)
                begin
                    status_next = STAT_IDLE_REL;
                end
                else if (pick.found)
                begin
                    ram_we             = 1'b1;
                    wdata              = cnt - 1'b1;
                    nonzero_next[addr] = (cnt != {{(COUNT_BITS - 1){1'b0}}, 1'b1});
                    head_next          = addr;
                    granted_next       = 1'b1;
                    gtrack_next        = TRACK_W'(addr);
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
            obusy_next = busy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            head_reg      <= '0;
            nonzero_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            head_reg      <= head_next;
            nonzero_reg   <= nonzero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= request.cmd;
            trk_reg <= trk_clamped;
        end
        granted_reg <= granted_next;
        gtrack_reg  <= gtrack_next;
        obusy_reg   <= obusy_next;
        status_reg  <= status_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.granted     = granted_reg;
    assign result.grant_track = gtrack_reg;
    assign result.disk_busy   = obusy_reg;
    assign result.status      = status_reg;

    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && granted_reg |-> obusy_reg)
        else $error("grant reported with disk idle");

    a_status_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != STAT_OK) |-> !granted_reg)
        else $error("error status together with grant");

    a_update_done: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("update did not publish its result");

    a_head_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (state_reg != ST_IDLE) || $stable(nonzero_reg) || $past(load))
        else $error("pending bitmap changed outside update");

endmodule

[design/csta_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module csta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/csta_finder.sv]
// Rotating priority encoder: first set bit at or above the start track, else the lowest set bit.
// Registers its pick when enabled. Depends on csta_pkg.
`timescale 1ns / 1ps

module csta_finder
    import csta_pkg::*;
#(
    parameter int USED_TRACKS = 128,
    parameter int IDX_W       = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [USED_TRACKS-1:0] nonzero,
    input  logic [IDX_W-1:0]       start,
    output pick_t                  pick
);

    pick_t                  pick_reg;
    pick_t                  pick_next;
    logic [USED_TRACKS-1:0] upper;
    logic                   upper_any;
    logic [IDX_W-1:0]       upper_idx;
    logic [IDX_W-1:0]       low_idx;

    always_comb
    begin
        for (int i = 0; i < USED_TRACKS; i++)
        begin
            upper[i] = nonzero[i] && (IDX_W'(i) >= start);
        end
    end

    always_comb
    begin
        upper_idx = '0;
        low_idx   = '0;
        for (int i = USED_TRACKS - 1; i >= 0; i--)
        begin
            if (upper[i])
            begin
                upper_idx = IDX_W'(i);
            end
            if (nonzero[i])
            begin
                low_idx = IDX_W'(i);
            end
        end
    end

    assign upper_any = |upper;

    always_comb
    begin
        pick_next.found = |nonzero;
        pick_next.idx   = TRACK_W'(upper_any ? upper_idx : low_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_reg <= '0;
        end
        else if (en)
        begin
            pick_reg <= pick_next;
        end
    end

    assign pick = pick_reg;

endmodule
